// ----- src/nal_to_annexb_framer_unit_macros.svh -----
// nal_to_annexb_framer_unit_macros.svh: assertion macros for the framer
// expects clk_i and rst_ni in the scope of each use
`ifndef NAL_TO_ANNEXB_FRAMER_UNIT_MACROS_SVH
`define NAL_TO_ANNEXB_FRAMER_UNIT_MACROS_SVH
`ifndef SYNTHESIS
// property must hold at every clock edge outside reset
`define N2AB_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// condition must never be seen outside reset
`define N2AB_ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define N2AB_ASSERT(label, prop, msg)
`define N2AB_ASSERT_NEVER(label, cond, msg)
`endif
`endif

// ----- src/n2ab_pkg.sv -----
// n2ab_pkg: item types, command format and constants of the annex b framer
// no dependencies
package n2ab_pkg;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       unit_first;
    logic       unit_last;
    logic       frame_first;
    logic       frame_last;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
    logic       frame_end;
    logic       params_changed;
  } out_item_t;

  localparam logic [7:0] TYPE_MASK  = 8'h1F;
  localparam logic [7:0] TYPE_SPS   = 8'd7;
  localparam logic [7:0] TYPE_PPS   = 8'd8;
  localparam logic [7:0] ESC_LIMIT  = 8'd3;
  localparam logic [7:0] ESC_BYTE   = 8'd3;
  localparam logic [7:0] START_BYTE = 8'd1;
  localparam logic [7:0] ZERO_BYTE  = 8'd0;

  localparam int unsigned INDEX_W = 13;
  localparam logic [INDEX_W-1:0] INDEX_MAX = 13'd8191;

  localparam int unsigned CMD_DEPTH = 4;
  localparam int unsigned CMD_PTR_W = 2;
  localparam int unsigned CMD_CNT_W = 3;

  typedef enum logic [1:0] {
    KIND_OTHER,
    KIND_SPS,
    KIND_PPS
  } kind_e;

  typedef enum logic [1:0] {
    MODE_UNDECIDED,
    MODE_PASS,
    MODE_ESCAPE
  } mode_e;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_PASS,
    OP_OPEN,
    OP_FEED
  } op_e;

  typedef enum logic [2:0] {
    BK_LOAD,
    BK_LEAD,
    BK_SC0,
    BK_SC1,
    BK_SC2,
    BK_BYTE
  } bk_state_e;

  // one classified input item, as handed from front to back
  typedef struct packed {
    op_e             op;
    kind_e           kind;
    logic            lead;
    logic            ffirst;
    logic            ufirst;
    logic            unit_end;
    logic            flast;
    logic [2:0]      cnt;
    logic [3:0][7:0] bytes;
  } cmd_t;

  function automatic kind_e kind_of(input logic [7:0] b);
    logic [7:0] t;
    t = b & TYPE_MASK;
    if (t == TYPE_SPS) begin
      return KIND_SPS;
    end else if (t == TYPE_PPS) begin
      return KIND_PPS;
    end
    return KIND_OTHER;
  endfunction

endpackage

// ----- src/nal_to_annexb_framer_unit.sv -----
// nal_to_annexb_framer_unit: top level of the h.264 nal unit to annex b framer
// depends on n2ab_pkg, n2ab_front, n2ab_cmd_fifo, n2ab_back
//
// Bytes of nal units go in on the push/full side, marked with unit and frame
// boundaries; the annex b stream comes out on the empty/pop side, one byte per
// item. The first bytes of each unit are held until it is known whether the
// unit already opens with 00 00 00 01 (then it passes through untouched);
// otherwise a 00 00 01 start code goes ahead of it, with an extra leading 00
// on the first such unit of a frame and on sps/pps units, and an 03 is put in
// wherever two emitted zeros precede a byte below 3. Sps and pps units are
// compared against stored copies (PARAM_BYTES bytes each, in one ram); the
// last byte of each frame carries frame_end and params_changed. The front
// classifies each input item as it is taken; the back loads each command and
// then emits its bytes: a plain payload byte, preceded by an 03 where needed,
// a unit opening preceded by its start code, and a held head byte emits nothing.
// The back sequencer, which puts out at most one byte per cycle, sets the
// sustained rate; the four-entry command queue lets the front keep taking items
// meanwhile, and byte output stalls while the single output register is unpopped.
module nal_to_annexb_framer_unit
  import n2ab_pkg::*;
#(
  parameter int unsigned PARAM_BYTES = 256
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  // input side
  input  logic      push,
  output logic      full,
  input  in_item_t  item_i,
  // result side
  output logic      empty,
  input  logic      pop,
  output out_item_t result_o
);

  cmd_t cmd_in, cmd_out;
  logic cmd_push, cmd_pop, cmd_full, cmd_empty;

  // front: head holding and unit classification
  n2ab_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .item_i     (item_i),
    .cmd_full_i (cmd_full),
    .cmd_push_o (cmd_push),
    .cmd_o      (cmd_in)
  );

  // decoupling queue, one command per accepted item
  n2ab_cmd_fifo u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .cmd_i   (cmd_in),
    .full_o  (cmd_full),
    .pop_i   (cmd_pop),
    .cmd_o   (cmd_out),
    .empty_o (cmd_empty)
  );

  // back: byte sequencer, escaping and parameter set tracking
  n2ab_back #(
    .PARAM_BYTES (PARAM_BYTES)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd_out),
    .cmd_empty_i (cmd_empty),
    .cmd_pop_o   (cmd_pop),
    .empty_o     (empty),
    .pop_i       (pop),
    .result_o    (result_o)
  );

  // input is taken whenever the command queue has room
  assign full = cmd_full;

endmodule

// ----- src/n2ab_ram.sv -----
// n2ab_ram: generic single write port, single read port ram, registered read
// no dependencies
module n2ab_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 512
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- src/n2ab_front.sv -----
// n2ab_front: holds unit heads, decides pass-through or start code, emits commands
// depends on n2ab_pkg
module n2ab_front
  import n2ab_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  in_item_t item_i,
  input  logic     cmd_full_i,
  output logic     cmd_push_o,
  output cmd_t     cmd_o
);

  logic [7:0] head_q [3];
  logic [1:0] hc_q, hc_d, hc;
  mode_e      mode_q, mode_d, mode;
  logic       pic_q, pic_d;
  logic       accept, unit_end, hold_wr;
  logic [7:0] b, first;
  kind_e      kind;
  cmd_t       cmd;

  assign accept = push_i && !cmd_full_i;
  assign b      = item_i.in_byte;
  assign unit_end = item_i.unit_last || item_i.frame_last;

  always_comb begin
    hc      = item_i.unit_first ? 2'd0 : hc_q;
    mode    = item_i.unit_first ? MODE_UNDECIDED : mode_q;
    pic_d   = item_i.frame_first ? 1'b0 : pic_q;
    hc_d    = hc;
    mode_d  = mode;
    hold_wr = 1'b0;
    first   = (hc != 2'd0) ? head_q[0] : b;
    kind    = kind_of(first);

    cmd          = '0;
    cmd.op       = OP_HOLD;
    cmd.kind     = KIND_OTHER;
    cmd.ffirst   = item_i.frame_first;
    cmd.ufirst   = item_i.unit_first;
    cmd.unit_end = unit_end;
    cmd.flast    = item_i.frame_last;
    cmd.cnt      = 3'd1;
    cmd.bytes    = {b, b, b, b};

    case (mode)
      MODE_UNDECIDED: begin
        if (hc == 2'd3 && head_q[0] == ZERO_BYTE && head_q[1] == ZERO_BYTE &&
            head_q[2] == ZERO_BYTE && b == START_BYTE) begin
          // unit already carries a four byte start code
          cmd.op    = OP_PASS;
          cmd.cnt   = 3'd4;
          cmd.bytes = {b, head_q[2], head_q[1], head_q[0]};
          mode_d    = MODE_PASS;
        end else if (hc == 2'd3 || unit_end) begin
          cmd.op   = OP_OPEN;
          cmd.kind = kind;
          cmd.lead = !pic_d || (kind != KIND_OTHER);
          cmd.cnt  = {1'b0, hc} + 3'd1;
          for (int i = 0; i < 3; i++) begin
            if (2'(i) < hc) begin
              cmd.bytes[i] = head_q[i];
            end
          end
          pic_d  = 1'b1;
          mode_d = MODE_ESCAPE;
          hc_d   = 2'd0;
        end else begin
          hold_wr = 1'b1;
          hc_d    = hc + 2'd1;
        end
      end
      MODE_PASS: begin
        cmd.op = OP_PASS;
      end
      default: begin
        cmd.op = OP_FEED;
      end
    endcase

    if (unit_end) begin
      mode_d = MODE_UNDECIDED;
      hc_d   = 2'd0;
    end
    if (item_i.frame_last) begin
      pic_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hc_q   <= 2'd0;
      mode_q <= MODE_UNDECIDED;
      pic_q  <= 1'b0;
    end else if (accept) begin
      hc_q   <= hc_d;
      mode_q <= mode_d;
      pic_q  <= pic_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && hold_wr) begin
      head_q[hc] <= b;
    end
  end

  assign cmd_push_o = accept;
  assign cmd_o      = cmd;

endmodule

// ----- src/n2ab_cmd_fifo.sv -----
// n2ab_cmd_fifo: short command queue between front and back
// depends on n2ab_pkg and the framer macro header
`include "nal_to_annexb_framer_unit_macros.svh"
module n2ab_cmd_fifo
  import n2ab_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t cmd_i,
  output logic full_o,
  input  logic pop_i,
  output cmd_t cmd_o,
  output logic empty_o
);

  localparam logic [CMD_CNT_W-1:0] DEPTH_CNT = CMD_CNT_W'(CMD_DEPTH);

  cmd_t                 mem_q [CMD_DEPTH];
  logic [CMD_PTR_W-1:0] wr_q, rd_q;
  logic [CMD_CNT_W-1:0] cnt_q, cnt_d;
  logic                 do_push, do_pop;

  assign full_o  = (cnt_q == DEPTH_CNT);
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign cmd_o   = mem_q[rd_q];

  always_comb begin
    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CMD_CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CMD_CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (do_push) begin
        wr_q <= wr_q + CMD_PTR_W'(1);
      end
      if (do_pop) begin
        rd_q <= rd_q + CMD_PTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= cmd_i;
    end
  end

  `N2AB_ASSERT(a_fifo_bound, cnt_q <= DEPTH_CNT, "command queue over capacity")
  `N2AB_ASSERT(a_fifo_grow, (do_push && !do_pop) |=> (cnt_q == $past(cnt_q) + 3'd1), "queue count did not grow")
  `N2AB_ASSERT_NEVER(a_fifo_overrun, push_i && full_o, "push into full command queue")

endmodule

// ----- src/n2ab_back.sv -----
// n2ab_back: emits start codes, escapes payload, tracks parameter set stores
// depends on n2ab_pkg, n2ab_ram and the framer macro header
`include "nal_to_annexb_framer_unit_macros.svh"
module n2ab_back
  import n2ab_pkg::*;
#(
  parameter int unsigned PARAM_BYTES = 256
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cmd_t      cmd_i,
  input  logic      cmd_empty_i,
  output logic      cmd_pop_o,
  output logic      empty_o,
  input  logic      pop_i,
  output out_item_t result_o
);

  localparam int unsigned AW        = $clog2(PARAM_BYTES);
  localparam int unsigned LW        = $clog2(PARAM_BYTES + 2);
  localparam int unsigned RAM_DEPTH = 2 * (2 ** AW);
  localparam logic [INDEX_W-1:0] PB_IDX  = INDEX_W'(PARAM_BYTES);
  localparam logic [LW-1:0]      PB_LEN1 = LW'(PARAM_BYTES + 1);

  bk_state_e        state_q, state_d;
  cmd_t             cmd_q, cmd_d;
  logic [1:0]       ptr_q, ptr_d;
  logic [1:0]       zr_q, zr_d;
  logic [INDEX_W-1:0] idx_q, idx_d, idx_inc;
  logic             mism_q, mism_d;
  kind_e            kind_q, kind_d;
  logic             flag_q, flag_d;
  logic [LW-1:0]    sps_len_q, sps_len_d, pps_len_q, pps_len_d, len_k, slen;
  logic             sps_pres_q, sps_pres_d, pps_pres_q, pps_pres_d, pres_k;
  logic             ovalid_q, ovalid_d;
  out_item_t        oitem_q, eitem;
  logic             emit, slot_free, is_last, need_esc, in_store;
  logic             cur_mism, mism_all, over, chg_sps, chg_pps, chg, flag_eff;
  logic [7:0]       cur_byte, rdata, store_data, byp_data_q;
  logic             byp_q, we;
  logic [AW:0]      waddr, raddr;

  assign slot_free = !ovalid_q || pop_i;
  assign cur_byte  = cmd_q.bytes[ptr_q];
  assign is_last   = ({1'b0, ptr_q} == cmd_q.cnt - 3'd1);
  assign store_data = byp_q ? byp_data_q : rdata;
  assign in_store  = (kind_q != KIND_OTHER) && (idx_q < PB_IDX);
  assign pres_k    = (kind_q == KIND_SPS) ? sps_pres_q : pps_pres_q;
  assign len_k     = (kind_q == KIND_SPS) ? sps_len_q : pps_len_q;
  assign cur_mism  = in_store && pres_k && (idx_q < INDEX_W'(len_k)) &&
                     (store_data != cur_byte);
  assign mism_all  = mism_q || cur_mism;
  assign idx_inc   = (idx_q == INDEX_MAX) ? idx_q : idx_q + INDEX_W'(1);
  assign over      = idx_inc > PB_IDX;
  assign slen      = over ? PB_LEN1 : idx_inc[LW-1:0];
  assign chg_sps   = sps_pres_q && ((slen != sps_len_q) || mism_all || over);
  assign chg_pps   = pps_pres_q && ((slen != pps_len_q) || mism_all || over);
  assign need_esc  = (cmd_q.op != OP_PASS) && (zr_q == 2'd2) && (cur_byte < ESC_LIMIT);

  always_comb begin
    state_d    = state_q;
    cmd_d      = cmd_q;
    ptr_d      = ptr_q;
    zr_d       = zr_q;
    idx_d      = idx_q;
    mism_d     = mism_q;
    kind_d     = kind_q;
    flag_d     = flag_q;
    sps_len_d  = sps_len_q;
    pps_len_d  = pps_len_q;
    sps_pres_d = sps_pres_q;
    pps_pres_d = pps_pres_q;
    cmd_pop_o  = 1'b0;
    emit       = 1'b0;
    eitem      = '0;
    we         = 1'b0;
    chg        = 1'b0;
    flag_eff   = flag_q;

    case (state_q)
      BK_LOAD: begin
        if (!cmd_empty_i) begin
          cmd_pop_o = 1'b1;
          cmd_d     = cmd_i;
          ptr_d     = 2'd0;
          if (cmd_i.ffirst) begin
            flag_d = 1'b0;
          end
          if (cmd_i.ufirst) begin
            zr_d   = 2'd0;
            idx_d  = '0;
            mism_d = 1'b0;
            kind_d = KIND_OTHER;
          end
          case (cmd_i.op)
            OP_HOLD: state_d = BK_LOAD;
            OP_OPEN: begin
              kind_d  = cmd_i.kind;
              zr_d    = 2'd0;
              state_d = cmd_i.lead ? BK_LEAD : BK_SC0;
            end
            default: state_d = BK_BYTE;
          endcase
        end
      end
      BK_LEAD: begin
        if (slot_free) begin
          emit           = 1'b1;
          eitem.out_byte = ZERO_BYTE;
          state_d        = BK_SC0;
        end
      end
      BK_SC0: begin
        if (slot_free) begin
          emit           = 1'b1;
          eitem.out_byte = ZERO_BYTE;
          state_d        = BK_SC1;
        end
      end
      BK_SC1: begin
        if (slot_free) begin
          emit           = 1'b1;
          eitem.out_byte = ZERO_BYTE;
          state_d        = BK_SC2;
        end
      end
      BK_SC2: begin
        if (slot_free) begin
          emit           = 1'b1;
          eitem.out_byte = START_BYTE;
          state_d        = BK_BYTE;
        end
      end
      BK_BYTE: begin
        if (slot_free) begin
          emit = 1'b1;
          if (need_esc) begin
            eitem.out_byte = ESC_BYTE;
            zr_d           = 2'd0;
          end else begin
            eitem.out_byte = cur_byte;
            eitem.run_last = is_last;
            ptr_d          = ptr_q + 2'd1;
            if (cmd_q.op != OP_PASS) begin
              we     = in_store;
              mism_d = mism_all;
              idx_d  = idx_inc;
              if (cur_byte == ZERO_BYTE) begin
                zr_d = (zr_q == 2'd2) ? 2'd2 : zr_q + 2'd1;
              end else begin
                zr_d = 2'd0;
              end
            end
            if (is_last) begin
              state_d = BK_LOAD;
              if (cmd_q.unit_end) begin
                if (cmd_q.op != OP_PASS) begin
                  case (kind_q)
                    KIND_SPS: begin
                      chg        = chg_sps;
                      sps_len_d  = slen;
                      sps_pres_d = 1'b1;
                      if (chg_sps) begin
                        pps_pres_d = 1'b0;
                        pps_len_d  = '0;
                      end
                    end
                    KIND_PPS: begin
                      chg        = chg_pps;
                      pps_len_d  = slen;
                      pps_pres_d = 1'b1;
                    end
                    default: chg = 1'b0;
                  endcase
                end
                zr_d   = 2'd0;
                idx_d  = '0;
                mism_d = 1'b0;
                kind_d = KIND_OTHER;
              end
              flag_eff             = flag_q || chg;
              eitem.frame_end      = cmd_q.flast;
              eitem.params_changed = cmd_q.flast && flag_eff;
              flag_d               = cmd_q.flast ? 1'b0 : flag_eff;
            end
          end
        end
      end
      default: state_d = BK_LOAD;
    endcase

    ovalid_d = ovalid_q;
    if (emit) begin
      ovalid_d = 1'b1;
    end else if (pop_i) begin
      ovalid_d = 1'b0;
    end
  end

  // store read runs every cycle at the index the next byte will use
  assign waddr = {kind_q == KIND_PPS, idx_q[AW-1:0]};
  assign raddr = {kind_d == KIND_PPS, idx_d[AW-1:0]};

  n2ab_ram #(
    .WIDTH (8),
    .DEPTH (RAM_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (cur_byte),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= BK_LOAD;
      ptr_q      <= '0;
      zr_q       <= '0;
      idx_q      <= '0;
      mism_q     <= 1'b0;
      kind_q     <= KIND_OTHER;
      flag_q     <= 1'b0;
      sps_len_q  <= '0;
      pps_len_q  <= '0;
      sps_pres_q <= 1'b0;
      pps_pres_q <= 1'b0;
      ovalid_q   <= 1'b0;
      byp_q      <= 1'b0;
    end else begin
      state_q    <= state_d;
      ptr_q      <= ptr_d;
      zr_q       <= zr_d;
      idx_q      <= idx_d;
      mism_q     <= mism_d;
      kind_q     <= kind_d;
      flag_q     <= flag_d;
      sps_len_q  <= sps_len_d;
      pps_len_q  <= pps_len_d;
      sps_pres_q <= sps_pres_d;
      pps_pres_q <= pps_pres_d;
      ovalid_q   <= ovalid_d;
      byp_q      <= we && (waddr == raddr);
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q      <= cmd_d;
    byp_data_q <= cur_byte;
    if (emit) begin
      oitem_q <= eitem;
    end
  end

  assign empty_o  = !ovalid_q;
  assign result_o = oitem_q;

  `N2AB_ASSERT(a_we_kind, we |-> (kind_q != KIND_OTHER), "store written outside a parameter set")
  `N2AB_ASSERT(a_sc_seq, (state_q == BK_SC2 && slot_free) |=> (state_q == BK_BYTE), "start code not followed by payload")
  `N2AB_ASSERT(a_end_last, (emit && eitem.frame_end) |-> eitem.run_last, "frame end on a non-final result")

endmodule
